// File: sv/line_sensor_steering_decision_assert.svh
// Assertion macros for the checker file of the steering block.
`ifndef LINE_SENSOR_STEERING_DECISION_ASSERT_SVH
`define LINE_SENSOR_STEERING_DECISION_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LSSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("steering block check failed");

// Next-cycle implication, disabled while reset is held.
`define LSSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("steering block check failed");

`endif

// File: sv/lssd_pkg.sv
// Package: constants, codes, types and the weight table of the steering block.
`timescale 1ns / 1ps
package lssd_pkg;

  localparam int unsigned DEF_NUM_SENSORS = 8;
  localparam int unsigned DEF_SAMPLE_BITS = 10;

  // Error magnitude and signed sum widths (sum stays within -15..17).
  localparam int unsigned QW    = 5;
  localparam int unsigned SUM_W = 6;
  localparam int unsigned OUT_W = 40;

  // Register indexes.
  localparam logic [2:0] REG_HIGH_THR   = 3'd0;
  localparam logic [2:0] REG_LOW_THR    = 3'd1;
  localparam logic [2:0] REG_STRAIGHT   = 3'd2;
  localparam logic [2:0] REG_TURN_OUTER = 3'd3;
  localparam logic [2:0] REG_TURN_INNER = 3'd4;
  localparam logic [2:0] REG_STR_BAND   = 3'd5;
  localparam logic [2:0] REG_TURN_BAND  = 3'd6;

  // Register reset values.
  localparam logic [9:0] HIGH_THR_RST   = 10'd800;
  localparam logic [9:0] LOW_THR_RST    = 10'd750;
  localparam logic [7:0] STRAIGHT_RST   = 8'd60;
  localparam logic [7:0] TURN_OUTER_RST = 8'd130;
  localparam logic [7:0] TURN_INNER_RST = 8'd40;
  localparam logic [4:0] STR_BAND_RST   = 5'd4;
  localparam logic [4:0] TURN_BAND_RST  = 5'd6;

  // Drive modes.
  localparam logic [2:0] MODE_NO_LINE  = 3'd0;
  localparam logic [2:0] MODE_STRAIGHT = 3'd1;
  localparam logic [2:0] MODE_LEFT     = 3'd2;
  localparam logic [2:0] MODE_RIGHT    = 3'd3;
  localparam logic [2:0] MODE_HOLD     = 3'd4;
  localparam logic [2:0] MODE_FINISHED = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Channel weight; channels past the eighth weigh nothing.
  function automatic logic signed [SUM_W-1:0] weight_of(input int unsigned idx);
    logic signed [SUM_W-1:0] w;
    case (idx)
      0:       w = -6'sd7;
      1:       w = -6'sd5;
      2:       w = -6'sd3;
      3:       w = 6'sd1;
      4:       w = 6'sd1;
      5:       w = 6'sd3;
      6:       w = 6'sd5;
      7:       w = 6'sd7;
      default: w = 6'sd0;
    endcase
    return w;
  endfunction

endpackage

// File: sv/lssd_div.sv
// Restoring divider: error magnitude over black count, one quotient bit per cycle.
`timescale 1ns / 1ps
module lssd_div
  import lssd_pkg::*;
#(
  parameter int unsigned CW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output div_stat_t     stat,
  output logic [QW-1:0] quotient
);

  localparam int unsigned SW = (QW > 1) ? $clog2(QW) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] dvs_r, dvs_nxt;
  logic [CW:0]   trial;
  logic          fits;

  assign trial = {rem_r, dvd_r[QW-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? CW'(trial - {1'b0, dvs_r}) : trial[CW-1:0];
      q_nxt    = {q_r[QW-2:0], fits};
      dvd_nxt  = {dvd_r[QW-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

// File: sv/line_sensor_steering_decision.sv
// Top level: line-sensor hysteresis, weighted centroid and PWM steering decision.
`timescale 1ns / 1ps
//
// Channel | Dir | Handshake              | Payload
// --------+-----+------------------------+-----------------------------------------
// in_     | in  | in_tvalid / in_tready   | in_tdata: sample_0 .. sample_N-1
// out_    | out | out_tvalid / out_tready | out_tdata: mask, count, error, mode, pwm
// cfg_    | in  | APB, pready tied high   | seven config registers at 4*i
//
// Sequencing: a beat runs through the channel-serial scan (one comparator and adder,
//   one channel a cycle) and the five-step restoring divider with its start and done
//   states; the divider is skipped when no channel is black.
// Reset: synchronous, active low; channels white, held pair zero, finished clear,
//   registers to their defaults.
// Stalls: in_tready is high only when idle; a result waiting in the output
//   register does not block the next scan, only the next result load.
module line_sensor_steering_decision
  import lssd_pkg::*;
#(
  parameter int unsigned NUM_SENSORS = DEF_NUM_SENSORS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample_0 .. sample_N-1, SAMPLE_BITS each, sample_0 lowest, zero pad to bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [((NUM_SENSORS*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // black_mask[7:0], black_count[11:8], steer_error[17:12], drive_mode[20:18],
  // left_pwm[28:21], right_pwm[36:29], zero[39:37]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [OUT_W-1:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned DW   = NUM_SENSORS * SAMPLE_BITS;
  localparam int unsigned IW   = $clog2(NUM_SENSORS);
  localparam int unsigned CW   = $clog2(NUM_SENSORS + 1);
  localparam int unsigned CMPW = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
  localparam int unsigned MW   = (NUM_SENSORS > 8) ? NUM_SENSORS : 8;
  localparam int unsigned CXW  = (CW > 4) ? CW : 4;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DIVST  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  // ---------------- configuration registers ----------------
  logic [9:0] hi_thr_r, lo_thr_r;
  logic [7:0] straight_r, outer_r, inner_r;
  logic [4:0] sband_r, tband_r;
  logic [2:0] cfg_idx;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_thr_r   <= HIGH_THR_RST;
      lo_thr_r   <= LOW_THR_RST;
      straight_r <= STRAIGHT_RST;
      outer_r    <= TURN_OUTER_RST;
      inner_r    <= TURN_INNER_RST;
      sband_r    <= STR_BAND_RST;
      tband_r    <= TURN_BAND_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HIGH_THR:   hi_thr_r   <= cfg_pwdata[9:0];
        REG_LOW_THR:    lo_thr_r   <= cfg_pwdata[9:0];
        REG_STRAIGHT:   straight_r <= cfg_pwdata[7:0];
        REG_TURN_OUTER: outer_r    <= cfg_pwdata[7:0];
        REG_TURN_INNER: inner_r    <= cfg_pwdata[7:0];
        REG_STR_BAND:   sband_r    <= cfg_pwdata[4:0];
        REG_TURN_BAND:  tband_r    <= cfg_pwdata[4:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HIGH_THR:   cfg_prdata = {22'd0, hi_thr_r};
      REG_LOW_THR:    cfg_prdata = {22'd0, lo_thr_r};
      REG_STRAIGHT:   cfg_prdata = {24'd0, straight_r};
      REG_TURN_OUTER: cfg_prdata = {24'd0, outer_r};
      REG_TURN_INNER: cfg_prdata = {24'd0, inner_r};
      REG_STR_BAND:   cfg_prdata = {27'd0, sband_r};
      REG_TURN_BAND:  cfg_prdata = {27'd0, tband_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- sequencer and datapath ----------------
  logic [2:0]              state_r, state_nxt;
  logic [DW-1:0]           samples_r;
  logic [IW-1:0]           chan_r, chan_nxt;
  logic [NUM_SENSORS-1:0]  chst_r, chst_nxt;     // hysteresis state per channel
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    fin_r, fin_nxt;
  logic [7:0]              held_l_r, held_l_nxt, held_r_r, held_r_nxt;
  logic                    ovalid_r, ovalid_nxt;
  logic [OUT_W-1:0]        odata_r, odata_nxt;

  logic                    in_beat;
  logic                    out_free;
  logic [SAMPLE_BITS-1:0]  samp;
  logic [CMPW-1:0]         samp_x, hi_x, lo_x;
  logic                    cur_bit, new_bit;
  logic signed [SUM_W-1:0] wgt;
  logic [SUM_W-1:0]        abs_sum;

  logic                    div_start;
  div_stat_t               div_stat;
  logic [QW-1:0]           div_q;

  logic [QW-1:0]           mag;
  logic signed [5:0]       err;
  logic [2:0]              mode;
  logic                    all_black;
  logic [MW-1:0]           mask_x;
  logic [CXW-1:0]          cnt_x;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid & in_tready;
  assign out_free  = ~ovalid_r | out_tready;

  // Shared comparator and weight adder, one channel a cycle.
  assign samp    = samples_r[chan_r*SAMPLE_BITS +: SAMPLE_BITS];
  assign samp_x  = CMPW'(samp);
  assign hi_x    = CMPW'(hi_thr_r);
  assign lo_x    = CMPW'(lo_thr_r);
  assign cur_bit = chst_r[chan_r];
  assign wgt     = weight_of(32'(chan_r));

  always_comb begin
    if (fin_r)                new_bit = cur_bit;   // frozen after finish
    else if (samp_x >= hi_x)  new_bit = 1'b1;      // black test wins on crossed thresholds
    else if (samp_x <= lo_x)  new_bit = 1'b0;
    else                      new_bit = cur_bit;
  end

  assign abs_sum   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign div_start = (state_r == ST_DIVST);

  lssd_div #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (abs_sum[QW-1:0]),
    .divisor  (cnt_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Decision from the finished scan.
  assign mag       = (cnt_r == '0) ? '0 : div_q;
  assign err       = sum_r[SUM_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign all_black = &chst_r;
  assign mask_x    = MW'(chst_r);
  assign cnt_x     = CXW'(cnt_r);

  always_comb begin
    held_l_nxt = held_l_r;
    held_r_nxt = held_r_r;
    fin_nxt    = fin_r;
    if (fin_r) begin
      mode = MODE_FINISHED;
    end else begin
      if (mag == '0) begin
        mode = MODE_NO_LINE;
      end else if (mag <= sband_r) begin
        mode       = MODE_STRAIGHT;
        held_l_nxt = straight_r;
        held_r_nxt = straight_r;
      end else if (mag >= tband_r) begin
        if (sum_r[SUM_W-1]) begin
          mode       = MODE_LEFT;
          held_l_nxt = outer_r;
          held_r_nxt = inner_r;
        end else begin
          mode       = MODE_RIGHT;
          held_l_nxt = inner_r;
          held_r_nxt = outer_r;
        end
      end else begin
        mode = MODE_HOLD;   // dead zone between the bands
      end
      if (all_black) begin
        fin_nxt    = 1'b1;
        held_l_nxt = '0;
        held_r_nxt = '0;
        mode       = MODE_FINISHED;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    chan_nxt   = chan_r;
    chst_nxt   = chst_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r & ~out_tready;
    odata_nxt  = odata_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          chan_nxt  = '0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        chst_nxt[chan_r] = new_bit;
        if (new_bit) begin
          sum_nxt = sum_r + wgt;
          cnt_nxt = cnt_r + 1'b1;
        end
        chan_nxt = chan_r + 1'b1;
        if (chan_r == IW'(NUM_SENSORS - 1)) begin
          state_nxt = (cnt_nxt == '0) ? ST_DECIDE : ST_DIVST;
        end
      end
      ST_DIVST: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        // Wait here while the previous result is still held.
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {3'd0,
                        fin_nxt ? 8'd0 : held_r_nxt,
                        fin_nxt ? 8'd0 : held_l_nxt,
                        mode,
                        err,
                        cnt_x[3:0],
                        mask_x[7:0]};
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      chst_r   <= '0;
      fin_r    <= 1'b0;
      held_l_r <= '0;
      held_r_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      chst_r   <= chst_nxt;
      ovalid_r <= ovalid_nxt;
      if (state_r == ST_DECIDE && out_free) begin
        fin_r    <= fin_nxt;
        held_l_r <= held_l_nxt;
        held_r_r <= held_r_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) samples_r <= in_tdata[DW-1:0];
    chan_r  <= chan_nxt;
    sum_r   <= sum_nxt;
    cnt_r   <= cnt_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

// File: sv/lssd_chk.sv
// Port-level checker for the steering block, bound to the top level.
`timescale 1ns / 1ps
`include "line_sensor_steering_decision_assert.svh"
module lssd_chk
  import lssd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result stays offered.
  `LSSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // The scan is multi-cycle: no second beat right after one is taken.
  `LSSD_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // Finished mode always commands both wheels to zero.
  `LSSD_ASSERT_IMPLY(a_fin_stop, clk, rst_n,
    out_tvalid && out_tdata[20:18] == MODE_FINISHED, out_tdata[36:21] == 16'd0)

  // No black channel means zero error.
  `LSSD_ASSERT_IMPLY(a_none_zero_err, clk, rst_n,
    out_tvalid && out_tdata[11:8] == 4'd0, out_tdata[17:12] == 6'd0)

endmodule

bind line_sensor_steering_decision lssd_chk u_lssd_chk (.*);
